[design/mpr_pkg.sv]
// Shared types and constants for the predictive pixel reconstruction block.
// Used by every module of the block; depends on nothing.
package mpr_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int QUEUE_DEPTH  = 4;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int PLANE_W    = 2;
  localparam int DIM_W      = 11;
  localparam int SHIFT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int CODED_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_U    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_V    = 3'd4;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  typedef enum logic [1:0] {
    KIND_ROW0,
    KIND_COL0,
    KIND_INNER
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [PLANE_W-1:0]  plane;
    logic                col_one;
    logic                done;
  } ctrl_t;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_cols;
    logic [DIM_W-1:0]   frame_rows;
    logic [SHIFT_W-1:0] shift_luma;
    logic [SHIFT_W-1:0] shift_chroma_u;
    logic [SHIFT_W-1:0] shift_chroma_v;
  } cfg_t;

endpackage

[design/mpr_queue.sv]
// Small register FIFO between the classifier and the reconstruction pipeline.
// Uses mpr_pkg for its default depth.
module mpr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mpr_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[design/mpr_front.sv]
// Input side: walks plane, phase, row and column for each accepted value and
// tags it for the reconstruction pipeline. Uses mpr_pkg.
module mpr_front #(
  parameter int MAX_COLS = mpr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mpr_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpr_pkg::cfg_t              cfg_i,
  input  logic                       accept_i,
  output mpr_pkg::ctrl_t             item_ctrl_o,
  output logic [$clog2(MAX_ROWS)-1:0] item_row_o,
  output logic [$clog2(MAX_COLS)-1:0] item_col_o
);
  import mpr_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CDW   = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
  localparam int RDW   = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;

  localparam logic [1:0] PH_ROW0  = 2'd0;
  localparam logic [1:0] PH_COL0  = 2'd1;
  localparam logic [1:0] PH_INNER = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [CDW-1:0]     cols_w, cols_c, cols_m1;
  logic [RDW-1:0]     rows_w, rows_c, rows_m1;
  logic               col_last, row_last;

  always_comb begin
    cols_w = CDW'(cfg_i.frame_cols);
    rows_w = RDW'(cfg_i.frame_rows);
    if (cols_w < CDW'(2)) begin
      cols_c = CDW'(2);
    end else if (cols_w > CDW'(MAX_COLS)) begin
      cols_c = CDW'(MAX_COLS);
    end else begin
      cols_c = cols_w;
    end
    if (rows_w < RDW'(2)) begin
      rows_c = RDW'(2);
    end else if (rows_w > RDW'(MAX_ROWS)) begin
      rows_c = RDW'(MAX_ROWS);
    end else begin
      rows_c = rows_w;
    end
    cols_m1  = cols_c - CDW'(1);
    rows_m1  = rows_c - RDW'(1);
    col_last = (CDW'(col_q) >= cols_m1);
    row_last = (RDW'(row_q) >= rows_m1);
  end

  always_comb begin
    phase_d = phase_q;
    plane_d = plane_q;
    row_d   = row_q;
    col_d   = col_q;
    item_ctrl_o.plane   = plane_q;
    item_ctrl_o.col_one = 1'b0;
    item_ctrl_o.done    = 1'b0;
    item_row_o          = row_q;
    item_col_o          = col_q;
    case (phase_q)
      PH_ROW0: begin
        item_ctrl_o.kind = KIND_ROW0;
        item_row_o       = '0;
        if (col_last) begin
          phase_d = PH_COL0;
          row_d   = ROW_W'(1);
          col_d   = '0;
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      PH_COL0: begin
        item_ctrl_o.kind = KIND_COL0;
        item_col_o       = '0;
        if (row_last) begin
          phase_d = PH_INNER;
          row_d   = ROW_W'(1);
          col_d   = COL_W'(1);
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      default: begin
        item_ctrl_o.kind    = KIND_INNER;
        item_ctrl_o.col_one = (col_q == COL_W'(1));
        if (col_last) begin
          col_d = COL_W'(1);
          if (row_last) begin
            item_ctrl_o.done = (plane_q >= PLANE_V);
            plane_d = (plane_q >= PLANE_V) ? PLANE_Y : plane_q + PLANE_W'(1);
            phase_d = PH_ROW0;
            row_d   = '0;
            col_d   = '0;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ROW0;
      plane_q <= PLANE_Y;
      row_q   <= '0;
      col_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      plane_q <= plane_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

[design/mpr_back.sv]
// Reconstruction pipeline: row and first-column stores, median edge predictor,
// residual add and the output register. Uses mpr_pkg.
module mpr_back #(
  parameter int MAX_COLS = mpr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mpr_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mpr_pkg::cfg_t                       cfg_i,
  input  logic                                q_valid_i,
  output logic                                q_pop_o,
  input  mpr_pkg::ctrl_t                      q_ctrl_i,
  input  logic [$clog2(MAX_ROWS)-1:0]         q_row_i,
  input  logic [$clog2(MAX_COLS)-1:0]         q_col_i,
  input  logic [mpr_pkg::PIX_W-1:0]           q_pix_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [mpr_pkg::PIX_W-1:0]           m_pixel_o,
  output logic [mpr_pkg::PLANE_W-1:0]         m_plane_o,
  output logic [mpr_pkg::POS_W-1:0]           m_row_o,
  output logic [mpr_pkg::POS_W-1:0]           m_col_o,
  output logic                                m_done_o
);
  import mpr_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [PIX_W-1:0] upper_row_mem [MAX_COLS];
  logic [PIX_W-1:0] first_col_mem [MAX_ROWS];

  // stage 1: store reads
  logic             s1_v_q;
  ctrl_t            s1_ctrl_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [PIX_W-1:0] b_mem_q, fc_a_q, fc_c_q, fwd_val_q;
  logic             fwd_q;

  logic [PIX_W-1:0] left_q, ul_q;

  // output register
  logic               out_v_q;
  logic [PIX_W-1:0]   out_pix_q;
  logic [PLANE_W-1:0] out_plane_q;
  logic [POS_W-1:0]   out_row_q, out_col_q;
  logic               out_done_q;

  logic               adv_out, load;
  logic [PIX_W-1:0]   a_c, b_c, c_c, hi_c, lo_c, pred_c, pix_c;
  logic [SHIFT_W-1:0] sh_c;
  logic               up_we;
  logic               fc_we;
  logic [ROW_W-1:0]   fc_wa;
  logic [ROW_W+POS_W-1:0] row_ext;
  logic [COL_W+POS_W-1:0] col_ext;

  assign adv_out = s1_v_q && (!out_v_q || m_ready_i);
  assign load    = q_valid_i && (!s1_v_q || adv_out);
  assign q_pop_o = load;

  always_comb begin
    a_c = s1_ctrl_q.col_one ? fc_a_q : left_q;
    c_c = s1_ctrl_q.col_one ? fc_c_q : ul_q;
    b_c = fwd_q ? fwd_val_q : b_mem_q;
    hi_c = (a_c > b_c) ? a_c : b_c;
    lo_c = (a_c > b_c) ? b_c : a_c;
    if (c_c >= hi_c) begin
      pred_c = lo_c;
    end else if (c_c <= lo_c) begin
      pred_c = hi_c;
    end else begin
      pred_c = a_c + b_c - c_c;
    end
    case (s1_ctrl_q.plane)
      PLANE_Y: sh_c = cfg_i.shift_luma;
      PLANE_U: sh_c = cfg_i.shift_chroma_u;
      default: sh_c = cfg_i.shift_chroma_v;
    endcase
    if (s1_ctrl_q.kind == KIND_INNER) begin
      pix_c = pred_c + (s1_pix_q << sh_c);
    end else begin
      pix_c = s1_pix_q;
    end
    up_we   = adv_out && (s1_ctrl_q.kind != KIND_COL0);
    fc_we   = load && ((q_ctrl_i.kind == KIND_COL0) ||
                       ((q_ctrl_i.kind == KIND_ROW0) && (q_col_i == '0)));
    fc_wa   = (q_ctrl_i.kind == KIND_COL0) ? q_row_i : '0;
    row_ext = {{POS_W{1'b0}}, s1_row_q};
    col_ext = {{POS_W{1'b0}}, s1_col_q};
  end

  always_ff @(posedge clk_i) begin
    if (up_we) begin
      upper_row_mem[s1_col_q] <= pix_c;
    end
    if (load) begin
      b_mem_q <= upper_row_mem[q_col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fc_we) begin
      first_col_mem[fc_wa] <= q_pix_i;
    end
    if (load) begin
      fc_a_q <= first_col_mem[q_row_i];
      fc_c_q <= first_col_mem[q_row_i - ROW_W'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_ctrl_q <= q_ctrl_i;
      s1_row_q  <= q_row_i;
      s1_col_q  <= q_col_i;
      s1_pix_q  <= q_pix_i;
      // two-column frames: the row above was written by the transaction ahead
      fwd_val_q <= pix_c;
    end
    if (adv_out) begin
      out_pix_q   <= pix_c;
      out_plane_q <= s1_ctrl_q.plane;
      out_row_q   <= row_ext[POS_W-1:0];
      out_col_q   <= col_ext[POS_W-1:0];
      out_done_q  <= s1_ctrl_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      fwd_q   <= 1'b0;
      left_q  <= '0;
      ul_q    <= '0;
    end else begin
      if (load) begin
        s1_v_q <= 1'b1;
        fwd_q  <= up_we && (s1_col_q == q_col_i);
      end else if (adv_out) begin
        s1_v_q <= 1'b0;
      end
      if (adv_out) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (adv_out && (s1_ctrl_q.kind == KIND_INNER)) begin
        left_q <= pix_c;
        ul_q   <= b_c;
      end
    end
  end

  assign m_valid_o = out_v_q;
  assign m_pixel_o = out_pix_q;
  assign m_plane_o = out_plane_q;
  assign m_row_o   = out_row_q;
  assign m_col_o   = out_col_q;
  assign m_done_o  = out_done_q;

  a_done_on_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_done_q) |-> (out_plane_q == PLANE_V))
    else $error("frame end flagged outside the V plane");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("queue popped while empty");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !adv_out) |-> !load)
    else $error("stage 1 overwritten while stalled");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_v_q))
    else $error("output raised without a stage 1 transaction");

endmodule

[design/med_predictive_pixel_reconstruct.sv]
// Top level of the median-edge predictive pixel reconstruction block.
// Depends on mpr_pkg, mpr_front, mpr_queue and mpr_back.
//
// Usage:
//   s_axis carries one coded value per transaction (tdata[8:0]). Per plane the
//   first row comes as raw bytes, then column 0 of rows 1 and up as raw bytes,
//   then the interior in raster order as residuals. Planes run Y, U, V, then a
//   new frame starts with Y.
//   m_axis returns one pixel per input transaction: tdata holds pixel, row and
//   column, tuser the plane, tlast marks the last pixel of the V plane.
//   cfg writes frame_cols, frame_rows and the three residual shifts by index;
//   cfg_ready_o is always high. Write only while the block is idle.
// Timing:
//   An input transaction passes through the queue, stage 1 and the output register.
//   Throughput is one transaction per cycle while m_axis is not stalled, set by
//   the combinational predictor stage and the one-write/one-read row store.
// Reset:
//   Position restarts at the Y plane, first row; shifts clear, dimensions go to
//   1024 x 1024. The row and column stores are not cleared.
// Back-pressure:
//   A 4-entry queue, stage 1 and the output register absorb stalls; s_axis
//   tready drops once the queue is full.
module med_predictive_pixel_reconstruct #(
  parameter int MAX_COLS = mpr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mpr_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // [8:0] coded_value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,   // pixel, pixel_row, pixel_col
  output logic [mpr_pkg::PLANE_W-1:0]      m_axis_tuser,   // plane
  output logic                             m_axis_tlast,   // frame_done
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mpr_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CTRL_W = $bits(ctrl_t);
  localparam int ITEM_W = ROW_W + COL_W + PIX_W + CTRL_W;

  cfg_t             cfg_q;
  logic             accept;
  logic             q_full, q_valid, q_pop;
  ctrl_t            f_ctrl, q_ctrl;
  logic [ROW_W-1:0] f_row, q_row;
  logic [COL_W-1:0] f_col, q_col;
  logic [PIX_W-1:0] q_pix;
  logic [ITEM_W-1:0] q_in, q_out;
  logic [POS_W-1:0] out_row, out_col;
  logic [PIX_W-1:0] out_pix;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_cols     <= DIM_W'(1024);
      cfg_q.frame_rows     <= DIM_W'(1024);
      cfg_q.shift_luma     <= '0;
      cfg_q.shift_chroma_u <= '0;
      cfg_q.shift_chroma_v <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_COLS: cfg_q.frame_cols     <= cfg_data_i;
        REG_FRAME_ROWS: cfg_q.frame_rows     <= cfg_data_i;
        REG_SHIFT_Y:    cfg_q.shift_luma     <= cfg_data_i[SHIFT_W-1:0];
        REG_SHIFT_U:    cfg_q.shift_chroma_u <= cfg_data_i[SHIFT_W-1:0];
        REG_SHIFT_V:    cfg_q.shift_chroma_v <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  mpr_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .item_ctrl_o (f_ctrl),
    .item_row_o  (f_row),
    .item_col_o  (f_col)
  );

  assign q_in = {f_row, f_col, s_axis_tdata[PIX_W-1:0], f_ctrl};

  mpr_queue #(
    .DATA_W (ITEM_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign q_ctrl = ctrl_t'(q_out[CTRL_W-1:0]);
  assign q_pix  = q_out[CTRL_W +: PIX_W];
  assign q_col  = q_out[CTRL_W + PIX_W +: COL_W];
  assign q_row  = q_out[CTRL_W + PIX_W + COL_W +: ROW_W];

  mpr_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_ctrl_i  (q_ctrl),
    .q_row_i   (q_row),
    .q_col_i   (q_col),
    .q_pix_i   (q_pix),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_pixel_o (out_pix),
    .m_plane_o (m_axis_tuser),
    .m_row_o   (out_row),
    .m_col_o   (out_col),
    .m_done_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_col, out_row, out_pix};

endmodule

[bench/med_predictive_pixel_reconstruct_test.sv]
// Self-checking bench for med_predictive_pixel_reconstruct: drives coded values, predicts each
// reconstructed pixel and compares every output transaction. Depends on mpr_pkg and the block.
`timescale 1ns / 1ps
module med_predictive_pixel_reconstruct_test;
  import mpr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_GAP     = 20;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [PLANE_W-1:0] plane;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               done;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // [8:0] coded_value
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;        // [7:0] pixel, [17:8] pixel_row, [27:18] pixel_col
  logic [PLANE_W-1:0]    m_axis_tuser;        // [1:0] plane
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  med_predictive_pixel_reconstruct dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic [DIM_W-1:0]   cols_reg = DIM_W'(1024);
  logic [DIM_W-1:0]   rows_reg = DIM_W'(1024);
  logic [SHIFT_W-1:0] shift_reg [3] = '{default: '0};
  logic [PIX_W-1:0]   upper_row [MAX_COLS_DEF];
  logic [PIX_W-1:0]   first_col [MAX_ROWS_DEF];
  logic [PIX_W-1:0]   left_pix = '0;
  logic [PIX_W-1:0]   upper_left_pix = '0;
  int unsigned        row_cnt = 0;
  int unsigned        col_cnt = 0;
  kind_e              phase = KIND_ROW0;
  logic [PLANE_W-1:0] plane_cnt = PLANE_Y;

  pixel_t      expected_pixels [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_stall_pct = 55;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned med_edge(input int unsigned a, b, c);
    int unsigned hi, lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (c >= hi) return lo;
    if (c <= lo) return hi;
    return a + b - c;
  endfunction

  function automatic pixel_t predict_pixel(input logic [CODED_W-1:0] cv);
    int unsigned cols, rows, pred;
    int residual;
    logic [PIX_W-1:0] above;
    pixel_t px;
    cols = clamp_dim(cols_reg, MAX_COLS_DEF);
    rows = clamp_dim(rows_reg, MAX_ROWS_DEF);
    px = '0;
    px.plane = plane_cnt;
    case (phase)
      KIND_ROW0: begin
        px.pixel = cv[PIX_W-1:0];
        px.col = POS_W'(col_cnt);
        upper_row[col_cnt] = cv[PIX_W-1:0];
        if (col_cnt == 0) first_col[0] = cv[PIX_W-1:0];
        if (col_cnt + 1 >= cols) begin
          phase = KIND_COL0;
          row_cnt = 1;
          col_cnt = 0;
        end else begin
          col_cnt++;
        end
      end
      KIND_COL0: begin
        px.pixel = cv[PIX_W-1:0];
        px.row = POS_W'(row_cnt);
        first_col[row_cnt] = cv[PIX_W-1:0];
        if (row_cnt + 1 >= rows) begin
          phase = KIND_INNER;
          row_cnt = 1;
          col_cnt = 1;
        end else begin
          row_cnt++;
        end
      end
      default: begin
        if (col_cnt == 1) begin
          left_pix = first_col[row_cnt];
          upper_left_pix = first_col[row_cnt-1];
        end
        above = upper_row[col_cnt];
        pred = med_edge(left_pix, above, upper_left_pix);
        residual = $signed(cv);
        px.pixel = PIX_W'(pred + (residual <<< shift_reg[plane_cnt]));
        px.row = POS_W'(row_cnt);
        px.col = POS_W'(col_cnt);
        upper_left_pix = above;
        upper_row[col_cnt] = px.pixel;
        left_pix = px.pixel;
        if (col_cnt + 1 >= cols) begin
          col_cnt = 1;
          if (row_cnt + 1 >= rows) begin
            if (plane_cnt == PLANE_V) begin
              px.done = 1'b1;
              plane_cnt = PLANE_Y;
            end else begin
              plane_cnt = plane_cnt + 1'b1;
            end
            phase = KIND_ROW0;
            row_cnt = 0;
            col_cnt = 0;
          end else begin
            row_cnt++;
          end
        end else begin
          col_cnt++;
        end
      end
    endcase
    return px;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_COLS: cols_reg = data;
      REG_FRAME_ROWS: rows_reg = data;
      REG_SHIFT_Y:    shift_reg[PLANE_Y] = data[SHIFT_W-1:0];
      REG_SHIFT_U:    shift_reg[PLANE_U] = data[SHIFT_W-1:0];
      REG_SHIFT_V:    shift_reg[PLANE_V] = data[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  // Waits until every pixel has come back, then writes all five registers.
  task automatic set_frame(input int unsigned cols, rows, sy, su, sv);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] vals [5];
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    idx = '{REG_FRAME_COLS, REG_FRAME_ROWS, REG_SHIFT_Y, REG_SHIFT_U, REG_SHIFT_V};
    vals = '{CFG_DATA_W'(cols), CFG_DATA_W'(rows), CFG_DATA_W'(sy), CFG_DATA_W'(su),
             CFG_DATA_W'(sv)};
    cfg_valid_i <= 1'b1;
    foreach (idx[i]) begin
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_reg(idx[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_coded(input logic [CODED_W-1:0] cv);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, cv};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(predict_pixel(cv));
    items_sent++;
  endtask

  // Random values until the current plane is complete; small residuals now and then.
  task automatic send_plane();
    logic [CODED_W-1:0] cv;
    do begin
      if ($urandom_range(0, 3) == 0) cv = CODED_W'($urandom_range(0, 15) - 8);
      else cv = CODED_W'($urandom_range(0, 511));
      send_coded(cv);
    end while (!(phase == KIND_ROW0 && col_cnt == 0));
  endtask

  // 3x3 planes: raw bytes with bit 8 set and clear, residuals at both ends, wrap-around.
  task automatic test_border_extremes();
    logic [CODED_W-1:0] plane_vals [9];
    plane_vals = '{9'h000, 9'h1FF, 9'h180, 9'h100, 9'h0FF, 9'h100, 9'h0FF, 9'h000, 9'h1FF};
    set_frame(3, 3, 7, 1, 0);
    repeat (3) foreach (plane_vals[i]) send_coded(plane_vals[i]);
  endtask

  // Out-of-range sizes: below two clamps to two, above the maximum clamps to the maximum;
  // the first row or column then runs on until the size is brought back into range.
  task automatic test_clamped_dimensions();
    set_frame(2047, 0, 3, 5, 7);
    repeat (100) send_coded(CODED_W'($urandom_range(0, 511)));
    set_frame(3, 0, 3, 5, 7);
    send_plane();
    set_frame(1, 2047, 3, 5, 7);
    repeat (100) send_coded(CODED_W'($urandom_range(0, 511)));
    set_frame(1, 3, 3, 5, 7);
    send_plane();
    set_frame(2, 2, 0, 7, 4);
    send_plane();
  endtask

  // Shrinking the width during the first row, then the height during the first column.
  task automatic test_resize_mid_plane();
    set_frame(8, 6, 2, 4, 6);
    repeat (5) send_coded(CODED_W'($urandom_range(0, 511)));
    set_frame(3, 6, 2, 4, 6);
    repeat (4) send_coded(CODED_W'($urandom_range(0, 511)));
    set_frame(3, 2, 2, 4, 6);
    repeat (3) send_plane();
  endtask

  task automatic test_random_frames();
    int unsigned target, cols, rows;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 55 : 0;
      recv_stall_pct = (mode == 0) ? 55 : (mode == 1) ? 32 : 0;
      target = items_sent + 430;
      while (items_sent < target) begin
        case ($urandom_range(0, 7))
          0: begin
            cols = 2;
            rows = 2;
          end
          1: begin
            cols = $urandom_range(30, 48);
            rows = $urandom_range(2, 4);
          end
          default: begin
            cols = $urandom_range(2, 12);
            rows = $urandom_range(2, 10);
          end
        endcase
        set_frame(cols, rows, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
        repeat (3) send_plane();
      end
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pixel = m_axis_tdata[7:0];
      got.row = m_axis_tdata[17:8];
      got.col = m_axis_tdata[27:18];
      got.plane = m_axis_tuser;
      got.done = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel transaction with none expected: %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel !== want.pixel) begin
          $display("%0t: pixel expected %0d actual %0d", $time, want.pixel, got.pixel);
          mismatch_count++;
        end
        if (got.plane !== want.plane) begin
          $display("%0t: plane expected %0d actual %0d", $time, want.plane, got.plane);
          mismatch_count++;
        end
        if (got.row !== want.row) begin
          $display("%0t: pixel_row expected %0d actual %0d", $time, want.row, got.row);
          mismatch_count++;
        end
        if (got.col !== want.col) begin
          $display("%0t: pixel_col expected %0d actual %0d", $time, want.col, got.col);
          mismatch_count++;
        end
        if (got.done !== want.done) begin
          $display("%0t: frame_done expected %0d actual %0d", $time, want.done, got.done);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_border_extremes();
    test_clamped_dimensions();
    test_resize_mid_plane();
    test_random_frames();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/mpr_pkg.sv
design/mpr_queue.sv
design/mpr_front.sv
design/mpr_back.sv
design/med_predictive_pixel_reconstruct.sv
bench/med_predictive_pixel_reconstruct_test.sv
